// ===== hdl/jsu_pkg.sv =====
// Package for the JSON string unescaper: length width, result and error codes,
// decoder state encoding, transaction bundle type and helper functions.
// No dependencies.
package jsu_pkg;

    localparam int LEN_W = 16;
    localparam int SUM_W = LEN_W + 1;
    localparam int MAX_DATA = 4;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ERR_EXPECTED_STRING = 4'd0,
        ERR_CONTROL_CHAR    = 4'd1,
        ERR_INCOMPLETE_ESC  = 4'd2,
        ERR_INVALID_ESC     = 4'd3,
        ERR_INCOMPLETE_UNI  = 4'd4,
        ERR_INVALID_UNI     = 4'd5,
        ERR_MISSING_LOW     = 4'd6,
        ERR_INVALID_LOW     = 4'd7,
        ERR_UNEXPECTED_LOW  = 4'd8,
        ERR_TOO_LONG        = 4'd9,
        ERR_UNTERMINATED    = 4'd10
    } t_err;

    typedef enum logic [8:0] {
        M_SEEK    = 9'b000000001,
        M_STR     = 9'b000000010,
        M_ESC     = 9'b000000100,
        M_HEX1    = 9'b000001000,
        M_NEED_BS = 9'b000010000,
        M_NEED_U  = 9'b000100000,
        M_HEX2    = 9'b001000000,
        M_DONE    = 9'b010000000,
        M_DRAIN   = 9'b100000000
    } t_mode;

    typedef enum logic [1:0] {
        TAIL_NONE  = 2'd0,
        TAIL_DONE  = 2'd1,
        TAIL_ERROR = 2'd2
    } t_tail;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_N  = 8'h6e;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_U  = 8'h75;
    localparam logic [15:0] BUF_SIZE_RESET = 16'd64;

    // All results caused by one text byte.
    typedef struct packed {
        logic [2:0]              ndata;
        logic [3:0][7:0]         data;
        t_tail                   tail;
        t_err                    code;
        logic [LEN_W-1:0]        base;
    } t_bundle;

    typedef struct packed {
        logic [2:0]      k;
        logic [3:0][7:0] bytes;
    } t_enc;

    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic t_enc utf8_enc(input logic [20:0] cp);
        t_enc e;
        e.bytes = '0;
        if (cp[20:7] == '0) begin
            e.k = 3'd1;
            e.bytes[0] = cp[7:0];
        end else if (cp[20:11] == '0) begin
            e.k = 3'd2;
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp[20:16] == '0) begin
            e.k = 3'd3;
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            e.k = 3'd4;
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

endpackage

// ===== hdl/jsu_if.sv =====
// Valid/ready channel interfaces for text bytes in and decoded results out.
// Depends on jsu_pkg.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jsu_out_if;
    logic              valid;
    logic              ready;
    jsu_pkg::t_kind    kind;
    logic [7:0]        out_byte;
    jsu_pkg::t_err     error_code;
    logic [15:0]       length_so_far;
    logic              last_of_run;

    modport source (output valid, output kind, output out_byte, output error_code,
                    output length_so_far, output last_of_run, input ready);
    modport sink   (input valid, input kind, input out_byte, input error_code,
                    input length_so_far, input last_of_run, output ready);
endinterface

// ===== hdl/jsu_decode.sv =====
// Parser state and one-byte step: escapes, \u joining, UTF-8 encoding,
// overflow and error detection. Produces one result bundle per transaction.
// Depends on jsu_pkg.
module jsu_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_eot,
    input  logic [15:0]      i_buf_size,
    output jsu_pkg::t_bundle o_bundle,
    output logic             o_has_result
);

    jsu_pkg::t_mode                 r_mode, n_mode;
    logic [15:0]                    r_acc, n_acc;
    logic [1:0]                     r_cnt, n_cnt;
    logic [9:0]                     r_hs, n_hs;
    logic [jsu_pkg::LEN_W-1:0]      r_count, n_count;

    logic [4:0]                     hv;
    logic [15:0]                    acc_new;
    logic [20:0]                    cp;
    logic [7:0]                     single;
    logic                           put_single;
    logic                           put_cp;
    jsu_pkg::t_enc                  enc;
    logic [jsu_pkg::SUM_W-1:0]      sum;
    logic                           ovf;
    jsu_pkg::t_bundle               b;

    assign hv      = jsu_pkg::hex_val(i_byte);
    assign acc_new = {r_acc[11:0], hv[3:0]};
    assign cp      = (r_mode == jsu_pkg::M_HEX2)
                   ? 21'h10000 + {1'b0, r_hs, acc_new[9:0]}
                   : {5'd0, acc_new};

    always_comb begin
        n_mode     = r_mode;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_hs       = r_hs;
        n_count    = r_count;
        single     = i_byte;
        put_single = 1'b0;
        put_cp     = 1'b0;
        b.ndata    = 3'd0;
        b.data     = '0;
        b.tail     = jsu_pkg::TAIL_NONE;
        b.code     = jsu_pkg::ERR_EXPECTED_STRING;
        b.base     = r_count;

        case (r_mode)
            jsu_pkg::M_SEEK: begin
                if (i_byte == jsu_pkg::CH_SPACE
                    || (i_byte >= jsu_pkg::CH_TAB && i_byte <= jsu_pkg::CH_CR)) begin
                    n_mode = r_mode;
                end else if (i_byte == jsu_pkg::CH_QUOTE) begin
                    n_count = '0;
                    n_mode  = jsu_pkg::M_STR;
                end else begin
                    b.tail = jsu_pkg::TAIL_ERROR;
                    b.code = jsu_pkg::ERR_EXPECTED_STRING;
                    n_mode = jsu_pkg::M_DRAIN;
                end
            end
            jsu_pkg::M_STR: begin
                if (i_byte == jsu_pkg::CH_QUOTE) begin
                    b.tail = jsu_pkg::TAIL_DONE;
                    n_mode = jsu_pkg::M_DONE;
                end else if (i_byte < jsu_pkg::CH_SPACE) begin
                    b.tail = jsu_pkg::TAIL_ERROR;
                    b.code = jsu_pkg::ERR_CONTROL_CHAR;
                    n_mode = jsu_pkg::M_DRAIN;
                end else if (i_byte == jsu_pkg::CH_BSL) begin
                    n_mode = jsu_pkg::M_ESC;
                end else begin
                    put_single = 1'b1;
                end
            end
            jsu_pkg::M_ESC: begin
                case (i_byte)
                    jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: begin
                        put_single = 1'b1;
                    end
                    jsu_pkg::CH_LC_B: begin
                        single = 8'h08;
                        put_single = 1'b1;
                    end
                    jsu_pkg::CH_LC_F: begin
                        single = 8'h0c;
                        put_single = 1'b1;
                    end
                    jsu_pkg::CH_LC_N: begin
                        single = 8'h0a;
                        put_single = 1'b1;
                    end
                    jsu_pkg::CH_LC_R: begin
                        single = 8'h0d;
                        put_single = 1'b1;
                    end
                    jsu_pkg::CH_LC_T: begin
                        single = 8'h09;
                        put_single = 1'b1;
                    end
                    jsu_pkg::CH_LC_U: begin
                        n_acc  = '0;
                        n_cnt  = '0;
                        n_mode = jsu_pkg::M_HEX1;
                    end
                    default: begin
                        b.tail = jsu_pkg::TAIL_ERROR;
                        b.code = jsu_pkg::ERR_INVALID_ESC;
                        n_mode = jsu_pkg::M_DRAIN;
                    end
                endcase
            end
            jsu_pkg::M_HEX1, jsu_pkg::M_HEX2: begin
                if (!hv[4]) begin
                    b.tail = jsu_pkg::TAIL_ERROR;
                    b.code = jsu_pkg::ERR_INVALID_UNI;
                    n_mode = jsu_pkg::M_DRAIN;
                end else begin
                    n_acc = acc_new;
                    n_cnt = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        if (r_mode == jsu_pkg::M_HEX1) begin
                            if (acc_new[15:10] == 6'b110110) begin
                                n_hs   = acc_new[9:0];
                                n_mode = jsu_pkg::M_NEED_BS;
                            end else if (acc_new[15:10] == 6'b110111) begin
                                b.tail = jsu_pkg::TAIL_ERROR;
                                b.code = jsu_pkg::ERR_UNEXPECTED_LOW;
                                n_mode = jsu_pkg::M_DRAIN;
                            end else begin
                                put_cp = 1'b1;
                            end
                        end else if (acc_new[15:10] != 6'b110111) begin
                            b.tail = jsu_pkg::TAIL_ERROR;
                            b.code = jsu_pkg::ERR_INVALID_LOW;
                            n_mode = jsu_pkg::M_DRAIN;
                        end else begin
                            put_cp = 1'b1;
                        end
                    end
                end
            end
            jsu_pkg::M_NEED_BS: begin
                if (i_byte == jsu_pkg::CH_BSL) begin
                    n_mode = jsu_pkg::M_NEED_U;
                end else begin
                    b.tail = jsu_pkg::TAIL_ERROR;
                    b.code = jsu_pkg::ERR_MISSING_LOW;
                    n_mode = jsu_pkg::M_DRAIN;
                end
            end
            jsu_pkg::M_NEED_U: begin
                if (i_byte == jsu_pkg::CH_LC_U) begin
                    n_acc  = '0;
                    n_cnt  = '0;
                    n_mode = jsu_pkg::M_HEX2;
                end else begin
                    b.tail = jsu_pkg::TAIL_ERROR;
                    b.code = jsu_pkg::ERR_MISSING_LOW;
                    n_mode = jsu_pkg::M_DRAIN;
                end
            end
            jsu_pkg::M_DONE, jsu_pkg::M_DRAIN: begin
                n_mode = r_mode;
            end
            default: begin
                n_mode = jsu_pkg::M_SEEK;
            end
        endcase

        if (put_cp) begin
            enc = jsu_pkg::utf8_enc(cp);
        end else begin
            enc.k     = 3'd1;
            enc.bytes = {24'd0, single};
        end

        sum = {1'b0, r_count} + jsu_pkg::SUM_W'(enc.k);
        ovf = (sum >= jsu_pkg::SUM_W'(i_buf_size)) || sum[jsu_pkg::LEN_W];

        if (put_single || put_cp) begin
            if (ovf) begin
                b.tail = jsu_pkg::TAIL_ERROR;
                b.code = jsu_pkg::ERR_TOO_LONG;
                n_mode = jsu_pkg::M_DRAIN;
            end else begin
                b.ndata = enc.k;
                b.data  = enc.bytes;
                n_count = sum[jsu_pkg::LEN_W-1:0];
                n_mode  = jsu_pkg::M_STR;
            end
        end

        if (i_eot) begin
            case (n_mode)
                jsu_pkg::M_SEEK: begin
                    b.tail = jsu_pkg::TAIL_ERROR;
                    b.code = jsu_pkg::ERR_EXPECTED_STRING;
                end
                jsu_pkg::M_STR: begin
                    b.tail = jsu_pkg::TAIL_ERROR;
                    b.code = jsu_pkg::ERR_UNTERMINATED;
                end
                jsu_pkg::M_ESC: begin
                    b.tail = jsu_pkg::TAIL_ERROR;
                    b.code = jsu_pkg::ERR_INCOMPLETE_ESC;
                end
                jsu_pkg::M_HEX1: begin
                    b.tail = jsu_pkg::TAIL_ERROR;
                    b.code = jsu_pkg::ERR_INCOMPLETE_UNI;
                end
                jsu_pkg::M_NEED_BS, jsu_pkg::M_NEED_U, jsu_pkg::M_HEX2: begin
                    b.tail = jsu_pkg::TAIL_ERROR;
                    b.code = jsu_pkg::ERR_MISSING_LOW;
                end
                default: begin
                    b.tail = b.tail;
                end
            endcase
            n_mode  = jsu_pkg::M_SEEK;
            n_acc   = '0;
            n_cnt   = '0;
            n_hs    = '0;
            n_count = '0;
        end
    end

    assign o_bundle     = b;
    assign o_has_result = (b.ndata != 3'd0) || (b.tail != jsu_pkg::TAIL_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= jsu_pkg::M_SEEK;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_hs    <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_hs    <= n_hs;
            r_count <= n_count;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == jsu_pkg::M_SEEK) |-> (r_count == '0))
        else $error("count not cleared while seeking");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == jsu_pkg::M_DRAIN || r_mode == jsu_pkg::M_DONE) |-> !o_has_result || i_eot
            || b.tail == jsu_pkg::TAIL_NONE)
        else $error("results produced after string end or error");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_eot) |=> (r_mode == jsu_pkg::M_SEEK && r_count == '0))
        else $error("end of text did not return to seek");

endmodule

// ===== hdl/jsu_emit.sv =====
// Result register: holds the bundle of one text byte and hands its results
// out one result per cycle while ready. Depends on jsu_pkg and jsu_if.
module jsu_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jsu_pkg::t_bundle i_bundle,
    output logic             o_can_load,
    jsu_out_if.source        o_out
);

    jsu_pkg::t_bundle r_bundle;
    logic             r_valid;
    logic [2:0]       r_idx;
    logic [2:0]       total;
    logic             last;
    logic             is_data;
    logic             fire;

    assign total   = r_bundle.ndata + {2'd0, r_bundle.tail != jsu_pkg::TAIL_NONE};
    assign last    = (r_idx + 3'd1) == total;
    assign is_data = r_idx < r_bundle.ndata;
    assign fire    = r_valid && o_out.ready;

    assign o_can_load = !r_valid || (o_out.ready && last);

    assign o_out.valid         = r_valid;
    assign o_out.last_of_run   = last;
    assign o_out.out_byte      = is_data ? r_bundle.data[r_idx[1:0]] : 8'd0;
    assign o_out.length_so_far = 16'(r_bundle.base + jsu_pkg::LEN_W'(r_idx)
                                     + jsu_pkg::LEN_W'(is_data));

    always_comb begin
        o_out.kind       = jsu_pkg::KIND_DATA;
        o_out.error_code = jsu_pkg::ERR_EXPECTED_STRING;
        if (!is_data) begin
            case (r_bundle.tail)
                jsu_pkg::TAIL_DONE: begin
                    o_out.kind = jsu_pkg::KIND_DONE;
                end
                jsu_pkg::TAIL_ERROR: begin
                    o_out.kind       = jsu_pkg::KIND_ERROR;
                    o_out.error_code = r_bundle.code;
                end
                default: begin
                    o_out.kind = jsu_pkg::KIND_DATA;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (fire) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx < total))
        else $error("result index past bundle end");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("bundle loaded over pending results");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && last && !i_load) |=> !r_valid)
        else $error("results continue after last of run");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !last) |=> (r_valid && r_idx == $past(r_idx) + 3'd1))
        else $error("result skipped or repeated");

endmodule

// ===== hdl/json_string_unescape_utf8_top.sv =====
// JSON string unescaper to UTF-8. Takes one text byte per transaction and
// returns data bytes, a completion marker or an error code per string; the
// destination capacity is written through i_cfg_we/i_cfg_data (reset 64).
// While o_out is ready, text streams at one byte per clock for bytes that
// cause zero or one result; a byte that causes more (up to five: a four-byte
// UTF-8 sequence plus an end-of-text error) holds off the next byte, as the
// single-entry result register hands out one result per cycle while ready.
// Depends on jsu_pkg, jsu_if, jsu_decode and jsu_emit.
module json_string_unescape_utf8_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    jsu_in_if.sink      i_in,
    jsu_out_if.source   o_out
);

    logic [15:0]      r_buf_size;
    logic             can_load;
    logic             accept;
    logic             has_result;
    jsu_pkg::t_bundle bundle;

    assign i_in.ready = can_load;
    assign accept     = i_in.valid && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_size <= jsu_pkg::BUF_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_buf_size <= i_cfg_data;
        end
    end

    jsu_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (i_in.text_byte),
        .i_eot        (i_in.end_of_text),
        .i_buf_size   (r_buf_size),
        .o_bundle     (bundle),
        .o_has_result (has_result)
    );

    jsu_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && has_result),
        .i_bundle   (bundle),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule
